/* hdl/pal_pkg.sv */
// Shared types and codes for the positional array list.
package pal_pkg;

    localparam int ACT_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 6;

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SH_CHK,
        S_SH_WR,
        S_GRAB,
        S_DN_CHK,
        S_DN_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_resp;

endpackage

/* hdl/pal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pal_core.sv */
// Sequencer that runs list operations over the element RAM one step at a time.
module pal_core #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  pal_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output pal_pkg::t_resp o_resp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W) + 1;

    pal_pkg::t_state           r_state, n_state;
    logic [pal_pkg::ACT_W-1:0] r_action, n_action;
    logic [DATA_WIDTH-1:0]     r_value, n_value;
    logic [XW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic [DATA_WIDTH-1:0]     r_rd, n_rd;
    pal_pkg::t_status          r_status, n_status;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         idx_x;
    logic [XW-1:0]         pos_m1;
    logic                  is_full;
    logic                  is_empty;
    logic                  bad_ins_pos;
    logic                  bad_pos;
    logic                  sh_done;
    logic                  dn_more;
    logic [63:0]           value_x;
    logic [63:0]           rd_x;
    logic [CW-1:0]         idx_up;
    logic [CW-1:0]         idx_dn;
    pal_pkg::t_status      eval_status;
    logic                  eval_ok;

    assign cnt_x       = XW'(r_count);
    assign idx_x       = XW'(r_idx);
    assign pos_m1      = r_pos - XW'(1);
    assign is_full     = (r_count == CW'(CAPACITY));
    assign is_empty    = (r_count == '0);
    assign bad_ins_pos = (r_pos == '0) || (r_pos > cnt_x + XW'(1));
    assign bad_pos     = (r_pos == '0) || (r_pos > cnt_x);
    assign sh_done     = (idx_x == pos_m1);
    assign dn_more     = (idx_x + XW'(1) < cnt_x);
    assign idx_up      = r_idx + CW'(1);
    assign idx_dn      = r_idx - CW'(1);
    assign value_x     = {32'b0, i_req.value};
    assign rd_x        = 64'($signed(r_rd));

    // Status of the captured action, judged against the current length.
    always_comb begin
        eval_status = pal_pkg::ST_OK;
        case (r_action)
            pal_pkg::ACT_APPEND: begin
                if (is_full) eval_status = pal_pkg::ST_FULL;
            end
            pal_pkg::ACT_INSERT: begin
                if (is_full)          eval_status = pal_pkg::ST_FULL;
                else if (bad_ins_pos) eval_status = pal_pkg::ST_RANGE;
            end
            pal_pkg::ACT_POP: begin
                if (is_empty) eval_status = pal_pkg::ST_EMPTY;
            end
            pal_pkg::ACT_REMOVE, pal_pkg::ACT_READ: begin
                if (is_empty)     eval_status = pal_pkg::ST_EMPTY;
                else if (bad_pos) eval_status = pal_pkg::ST_RANGE;
            end
            default: eval_status = pal_pkg::ST_OK;
        endcase
    end

    assign eval_ok = (eval_status == pal_pkg::ST_OK);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pal_pkg::S_IDLE: begin
                if (i_req_valid) n_state = pal_pkg::S_EVAL;
            end
            pal_pkg::S_EVAL: begin
                if (!eval_ok) begin
                    n_state = pal_pkg::S_RESP;
                end else begin
                    case (r_action)
                        pal_pkg::ACT_INSERT: n_state = pal_pkg::S_SH_CHK;
                        pal_pkg::ACT_POP,
                        pal_pkg::ACT_REMOVE,
                        pal_pkg::ACT_READ:   n_state = pal_pkg::S_GRAB;
                        default:             n_state = pal_pkg::S_RESP;
                    endcase
                end
            end
            pal_pkg::S_SH_CHK: n_state = sh_done ? pal_pkg::S_RESP : pal_pkg::S_SH_WR;
            pal_pkg::S_SH_WR:  n_state = pal_pkg::S_SH_CHK;
            pal_pkg::S_GRAB: begin
                n_state = (r_action == pal_pkg::ACT_REMOVE) ? pal_pkg::S_DN_CHK
                                                            : pal_pkg::S_RESP;
            end
            pal_pkg::S_DN_CHK: n_state = dn_more ? pal_pkg::S_DN_WR : pal_pkg::S_RESP;
            pal_pkg::S_DN_WR:  n_state = pal_pkg::S_DN_CHK;
            pal_pkg::S_RESP: begin
                if (i_resp_ready) n_state = pal_pkg::S_IDLE;
            end
            default: n_state = pal_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and register updates.
    always_comb begin
        n_action  = r_action;
        n_value   = r_value;
        n_pos     = r_pos;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd      = r_rd;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = r_value;
        ram_raddr = idx_dn[AW-1:0];
        o_req_ready  = 1'b0;
        o_resp_valid = 1'b0;
        case (r_state)
            pal_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_action = i_req.action;
                    n_value  = value_x[DATA_WIDTH-1:0];
                    n_pos    = XW'(i_req.position);
                end
            end
            pal_pkg::S_EVAL: begin
                n_status = eval_status;
                n_rd     = '0;
                if (eval_ok) begin
                    case (r_action)
                        pal_pkg::ACT_APPEND: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                        end
                        pal_pkg::ACT_INSERT: begin
                            n_idx = r_count;
                        end
                        pal_pkg::ACT_POP: begin
                            ram_raddr = AW'(r_count - CW'(1));
                        end
                        pal_pkg::ACT_REMOVE, pal_pkg::ACT_READ: begin
                            ram_raddr = pos_m1[AW-1:0];
                            n_idx     = pos_m1[CW-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pal_pkg::S_SH_CHK: begin
                // Either drop the new value into its slot or fetch the element below.
                if (sh_done) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pal_pkg::S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_dn;
            end
            pal_pkg::S_GRAB: begin
                n_rd = ram_rdata;
                if (r_action == pal_pkg::ACT_POP) n_count = r_count - CW'(1);
            end
            pal_pkg::S_DN_CHK: begin
                ram_raddr = idx_up[AW-1:0];
                if (!dn_more) n_count = r_count - CW'(1);
            end
            pal_pkg::S_DN_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_up;
            end
            pal_pkg::S_RESP: begin
                o_resp_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pal_pkg::S_IDLE;
            r_count  <= '0;
            r_status <= pal_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_value  <= n_value;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
    end

    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_resp.read_value = rd_x[31:0];
    assign o_resp.status     = r_status;
    assign o_resp.count      = pal_pkg::COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == pal_pkg::S_EVAL))
        else $error("accepted item did not enter evaluation");

    a_shift_up_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pal_pkg::S_SH_WR) |-> (r_idx != '0 && idx_x > pos_m1))
        else $error("upward shift index out of range");

    a_shift_dn_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pal_pkg::S_DN_WR) |-> (idx_x + XW'(1) < cnt_x))
        else $error("downward shift past the end of the list");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pal_pkg::S_EVAL && r_state != pal_pkg::S_SH_CHK &&
         r_state != pal_pkg::S_GRAB && r_state != pal_pkg::S_DN_CHK) |=> $stable(r_count))
        else $error("count changed outside an update step");

endmodule

/* hdl/positional_array_list_top.sv */
// Top level of the positional array list: stream ports, sequencer and result register.
//
// A bounded ordered list of up to CAPACITY elements of DATA_WIDTH bits, held in
// one single-port-write, registered-read RAM. Each input transfer carries an
// action in s_axis_tuser (append, insert at a 1-based position, remove last,
// remove at a position, read at a position) and gives exactly one output
// transfer with the value read or removed, a status code and the new length.
// The block takes one item at a time. An insert at position p moves the
// elements from p to the end up by one place, and a remove at p moves those
// after p down by one. Every element moved by an insert or a remove costs one
// RAM read and one RAM write in successive cycles, since the RAM has a single
// read and a single write port with registered read data. The result sits in
// an output register, so the next item is accepted while an earlier result
// still waits for m_axis_tready; a new result waits in the sequencer only if
// the register is still occupied. Values narrower than 32 bits keep their low
// DATA_WIDTH bits and are read back sign-extended. The element RAM is not
// cleared at reset; only data read from entries below the current length is
// ever used.
module positional_array_list_top #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] value, [37:32] position, [39:38] zero
    input  logic [2:0]  s_axis_tuser,  // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] read_value, [37:32] count, [39:38] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    pal_pkg::t_req  req;
    pal_pkg::t_resp core_resp;
    logic           core_resp_valid;
    logic           core_resp_ready;

    // Output register holding one finished result.
    logic           r_out_valid;
    pal_pkg::t_resp r_out;

    assign req.action   = s_axis_tuser;
    assign req.value    = s_axis_tdata[31:0];
    assign req.position = s_axis_tdata[37:32];

    pal_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req        (req),
        .o_resp_valid (core_resp_valid),
        .i_resp_ready (core_resp_ready),
        .o_resp       (core_resp)
    );

    // The register can take a new result when empty or when its content leaves now.
    assign core_resp_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_resp_valid && core_resp_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_resp_valid && core_resp_ready) begin
            r_out <= core_resp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.count, r_out.read_value};
    assign m_axis_tuser  = r_out.status;

endmodule
